// ===== sv/tvb_pkg.sv =====
// shared types and constants for the transformed vertex bounding box unit
`default_nettype none

package tvb_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned AXES    = 3;
  localparam int unsigned ROW_W   = 64;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned FRAC_SH = 12;
  localparam int unsigned FLOOR_W = SUM_W - FRAC_SH;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [ROW_W-1:0] ROW_X_RESET = 64'd4096;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'd268435456;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'd17592186044416;

  typedef enum logic [1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic                      last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
  } box_t;

endpackage

`default_nettype wire

// ===== sv/transformed_vertex_bounding_box_unit.sv =====
// top level: affine vertex transform with running per-axis bounding box
`default_nettype none

// Takes one Q8.8 vertex per cycle unless vertex_stall is high, transforms
// it by the three configured rows (Q4.12 coefficients plus Q8.8
// translation), rounds each row down to Q8.8 with saturation and tracks the
// per-axis min and max. On the vertex flagged last the box is emitted and
// the trackers clear. Vertices flow through an input register, a product
// register and a rounded-coordinate register into the min/max trackers and
// the box output register. The only back-pressure comes from the single box
// output register: vertex_stall rises while a last vertex waits at the
// trackers and the previous box has not been taken. The user must write rows
// only while the unit is idle; the unit itself does not enforce this.
module transformed_vertex_bounding_box_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vertex_valid,
  output logic                  vertex_stall,
  input  wire tvb_pkg::vertex_t vertex,
  output logic                  box_valid,
  input  wire logic             box_stall,
  output tvb_pkg::box_t         box,
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [63:0]      cfg_data
);
  import tvb_pkg::*;

  logic [ROW_W-1:0] row [AXES];

  logic                      s1_valid;
  logic                      s1_last;
  logic signed [COORD_W-1:0] s1_v [AXES];

  logic                      s2_valid;
  logic                      s2_last;
  logic signed [PROD_W-1:0]  s2_prod [AXES][AXES];
  logic signed [15:0]        s2_trans [AXES];

  logic                      s3_valid;
  logic                      s3_last;
  logic signed [COORD_W-1:0] s3_coord [AXES];

  logic signed [COORD_W-1:0] low_corner [AXES];
  logic signed [COORD_W-1:0] high_corner [AXES];
  logic signed [COORD_W-1:0] low_next [AXES];
  logic signed [COORD_W-1:0] high_next [AXES];
  logic signed [COORD_W-1:0] coord_next [AXES];

  logic blocked;
  logic advance;

  // configuration rows
  always_ff @(posedge clk) begin
    if (rst) begin
      row[REG_ROW_X] <= ROW_X_RESET;
      row[REG_ROW_Y] <= ROW_Y_RESET;
      row[REG_ROW_Z] <= ROW_Z_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_ROW_X: row[REG_ROW_X] <= cfg_data;
        REG_ROW_Y: row[REG_ROW_Y] <= cfg_data;
        REG_ROW_Z: row[REG_ROW_Z] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign blocked      = s3_valid && s3_last && box_valid && box_stall;
  assign advance      = !blocked;
  assign vertex_stall = blocked;

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= vertex_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_v[0] <= vertex.vertex_x;
      s1_v[1] <= vertex.vertex_y;
      s1_v[2] <= vertex.vertex_z;
      s1_last <= vertex.last_vertex;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_last <= s1_last;
      for (int i = 0; i < AXES; i++) begin
        s2_trans[i] <= $signed(row[i][63:48]);
        for (int j = 0; j < AXES; j++) begin
          s2_prod[i][j] <= $signed(row[i][16*j +: 16]) * s1_v[j];
        end
      end
    end
  end

  // row sum, round down to q8.8, saturate
  always_comb begin
    logic signed [SUM_W-1:0]   sum;
    logic signed [FLOOR_W-1:0] fl;
    for (int i = 0; i < AXES; i++) begin
      sum = SUM_W'(s2_prod[i][0]) + SUM_W'(s2_prod[i][1]) + SUM_W'(s2_prod[i][2])
          + $signed({{(SUM_W-16-FRAC_SH){s2_trans[i][15]}}, s2_trans[i],
                     {FRAC_SH{1'b0}}});
      fl = sum[SUM_W-1:FRAC_SH];
      if (fl > FLOOR_W'(COORD_MAX)) begin
        coord_next[i] = COORD_MAX;
      end else if (fl < FLOOR_W'(COORD_MIN)) begin
        coord_next[i] = COORD_MIN;
      end else begin
        coord_next[i] = fl[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_last <= s2_last;
      for (int i = 0; i < AXES; i++) begin
        s3_coord[i] <= coord_next[i];
      end
    end
  end

  // min/max merge
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      low_next[i]  = (s3_coord[i] < low_corner[i])  ? s3_coord[i] : low_corner[i];
      high_next[i] = (s3_coord[i] > high_corner[i]) ? s3_coord[i] : high_corner[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        low_corner[i]  <= COORD_MAX;
        high_corner[i] <= COORD_MIN;
      end
    end else if (advance && s3_valid) begin
      for (int i = 0; i < AXES; i++) begin
        low_corner[i]  <= s3_last ? COORD_MAX : low_next[i];
        high_corner[i] <= s3_last ? COORD_MIN : high_next[i];
      end
    end
  end

  // box output register
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (advance && s3_valid && s3_last) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid && s3_last) begin
      box.box_min_x <= low_next[0];
      box.box_min_y <= low_next[1];
      box.box_min_z <= low_next[2];
      box.box_max_x <= high_next[0];
      box.box_max_y <= high_next[1];
      box.box_max_z <= high_next[2];
    end
  end

endmodule

`default_nettype wire

// ===== sv/tvb_checker.sv =====
// port-level assertions for the transformed vertex bounding box unit
`default_nettype none

module tvb_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             vertex_valid,
  input wire logic             vertex_stall,
  input wire tvb_pkg::vertex_t vertex,
  input wire logic             box_valid,
  input wire logic             box_stall,
  input wire tvb_pkg::box_t    box
);
  import tvb_pkg::*;

  // a waiting box holds
  a_box_hold: assert property (@(posedge clk) disable iff (rst)
    box_valid && box_stall |=> box_valid && $stable(box))
    else $error("box changed while stalled");

  // input back-pressure only comes from a stalled box
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    vertex_stall |-> box_valid && box_stall)
    else $error("vertex stall without waiting box");

  // no box right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !box_valid)
    else $error("box valid after reset");

  // every emitted box is ordered on each axis
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> box.box_min_x <= box.box_max_x && box.box_min_y <= box.box_max_y
                  && box.box_min_z <= box.box_max_z)
    else $error("box corners out of order");

endmodule

bind transformed_vertex_bounding_box_unit tvb_checker u_tvb_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex_valid (vertex_valid),
  .vertex_stall (vertex_stall),
  .vertex       (vertex),
  .box_valid    (box_valid),
  .box_stall    (box_stall),
  .box          (box)
);

`default_nettype wire

// ===== bench/tvb_box_checker.sv =====
// checker: predicts bounding boxes from observed transfers and compares them with the unit's output
module tvb_box_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             vertex_valid,
  input  logic             vertex_stall,
  input  tvb_pkg::vertex_t vertex,
  input  logic             box_valid,
  input  logic             box_stall,
  input  tvb_pkg::box_t    box,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  output int unsigned      boxes_due,
  output int unsigned      mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import tvb_pkg::*;

  logic [ROW_W-1:0]          rows [AXES];
  logic signed [COORD_W-1:0] lo_corner [AXES];
  logic signed [COORD_W-1:0] hi_corner [AXES];
  box_t                      expected_boxes [$];
  int unsigned               fail_total = 0;

  function automatic logic signed [COORD_W-1:0] transform_axis(input logic [ROW_W-1:0] row,
                                                               input vertex_t v);
    longint acc;
    acc = longint'(signed'(row[63:48])) * 4096;
    acc += longint'(signed'(row[15:0])) * longint'(v.vertex_x);
    acc += longint'(signed'(row[31:16])) * longint'(v.vertex_y);
    acc += longint'(signed'(row[47:32])) * longint'(v.vertex_z);
    acc = acc >>> FRAC_SH;
    if (acc > longint'(COORD_MAX)) begin
      acc = longint'(COORD_MAX);
    end else if (acc < longint'(COORD_MIN)) begin
      acc = longint'(COORD_MIN);
    end
    return acc[COORD_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic signed [COORD_W-1:0] want,
                             input logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_total++;
    end
  endtask

  task automatic clear_corners();
    for (int i = 0; i < AXES; i++) begin
      lo_corner[i] = COORD_MAX;
      hi_corner[i] = COORD_MIN;
    end
  endtask

  always @(posedge clk) begin : track
    box_t                      want;
    logic signed [COORD_W-1:0] coord;
    if (rst) begin
      rows[REG_ROW_X] = ROW_X_RESET;
      rows[REG_ROW_Y] = ROW_Y_RESET;
      rows[REG_ROW_Z] = ROW_Z_RESET;
      clear_corners();
      expected_boxes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ROW_X: rows[REG_ROW_X] = cfg_data;
          REG_ROW_Y: rows[REG_ROW_Y] = cfg_data;
          REG_ROW_Z: rows[REG_ROW_Z] = cfg_data;
          default: ;
        endcase
      end
      if (box_valid && !box_stall) begin
        if (expected_boxes.size() == 0) begin
          $display("%0t: box transfer with none expected, expected nothing got %h", $time, box);
          fail_total++;
        end else begin
          want = expected_boxes.pop_front();
          check_field("box_min_x", want.box_min_x, box.box_min_x);
          check_field("box_min_y", want.box_min_y, box.box_min_y);
          check_field("box_min_z", want.box_min_z, box.box_min_z);
          check_field("box_max_x", want.box_max_x, box.box_max_x);
          check_field("box_max_y", want.box_max_y, box.box_max_y);
          check_field("box_max_z", want.box_max_z, box.box_max_z);
        end
      end
      if (vertex_valid && !vertex_stall) begin
        for (int i = 0; i < AXES; i++) begin
          coord = transform_axis(rows[i], vertex);
          if (coord < lo_corner[i]) lo_corner[i] = coord;
          if (coord > hi_corner[i]) hi_corner[i] = coord;
        end
        if (vertex.last_vertex) begin
          want.box_min_x = lo_corner[0];
          want.box_min_y = lo_corner[1];
          want.box_min_z = lo_corner[2];
          want.box_max_x = hi_corner[0];
          want.box_max_y = hi_corner[1];
          want.box_max_z = hi_corner[2];
          expected_boxes.push_back(want);
          clear_corners();
        end
      end
    end
    boxes_due  <= expected_boxes.size();
    mismatches <= fail_total;
  end

endmodule

// ===== bench/tb_transformed_vertex_bounding_box_unit.sv =====
// testbench top: drives vertex sets, box back-pressure and row writes, and reports the verdict
module tb_transformed_vertex_bounding_box_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tvb_pkg::*;

  localparam logic [1:0]  REG_UNUSED     = 2'd3;
  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_VERTICES = 164;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        vertex_valid = 1'b0;
  vertex_t     vertex       = '0;
  logic        box_stall    = 1'b0;
  logic        cfg_wr_en    = 1'b0;
  logic [1:0]  cfg_index    = REG_ROW_X;
  logic [63:0] cfg_data     = '0;
  logic        vertex_stall;
  logic        box_valid;
  box_t        box;
  int unsigned boxes_due;
  int unsigned mismatches;
  int unsigned idle_cycles  = 0;
  bit          no_idle      = 1'b0;

  transformed_vertex_bounding_box_unit dut (.*);

  tvb_box_checker box_check (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if ((vertex_valid && !vertex_stall) || (box_valid && !box_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("transformed_vertex_bounding_box_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] make_row(input logic [15:0] cx, cy, cz, tr);
    return {tr, cz, cy, cx};
  endfunction

  function automatic logic [63:0] pick_row();
    logic [15:0] lane [4];
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: begin
        for (int i = 0; i < 4; i++) lane[i] = 16'($urandom_range(0, 8192) - 4096);
      end
      2: begin
        for (int i = 0; i < 4; i++) lane[i] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
      default: begin
        for (int i = 0; i < 3; i++) lane[i] = 16'h0000;
        lane[$urandom_range(0, 2)] = 16'h1000;
        lane[3] = 16'($urandom);
      end
    endcase
    return make_row(lane[0], lane[1], lane[2], lane[3]);
  endfunction

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 1024)) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vertex(input logic signed [15:0] x, y, z, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      vertex_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex       <= {x, y, z, last};
    do @(posedge clk); while (vertex_stall);
  endtask

  task automatic send_set(input int unsigned count);
    for (int unsigned n = 1; n <= count; n++) begin
      send_vertex(pick_coord(), pick_coord(), pick_coord(), n == count);
    end
  endtask

  // pause the vertex stream until every box is out and the pipeline is empty
  task automatic drain();
    vertex_valid <= 1'b0;
    @(posedge clk);
    while (boxes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rows(input logic [63:0] rx, ry, rz, input bit add_stray);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ROW_X;
    cfg_data  <= rx;
    @(posedge clk);
    cfg_index <= REG_ROW_Y;
    cfg_data  <= ry;
    @(posedge clk);
    cfg_index <= REG_ROW_Z;
    cfg_data  <= rz;
    @(posedge clk);
    if (add_stray) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : box_sink
    int unsigned hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        box_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      box_stall <= 1'b0;
      do @(posedge clk); while (!box_valid);
    end
  end

  initial begin : stimulus
    int unsigned remaining;
    int unsigned set_len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // identity rows after reset: single-vertex sets at the extremes, one longer set
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    send_vertex(16'sh7FFF, 16'sh8000, 16'sh0001, 1'b0);
    send_vertex(-16'sd1, 16'sd256, -16'sd256, 1'b1);
    send_vertex(16'sh5555, 16'shAAAA, 16'sh00FF, 1'b1);
    drain();

    // saturating rows, plus a write to the unused index that must change nothing
    write_rows(make_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
               make_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
               make_row(16'h8000, 16'h7FFF, 16'h0000, 16'h8000), 1'b1);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    send_vertex(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0);
    send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    send_vertex(16'sd1, -16'sd1, 16'sd1, 1'b1);
    drain();

    // tiny coefficients so rounding toward minus infinity shows
    write_rows(make_row(16'h0001, 16'h0000, 16'h0000, 16'h0000),
               make_row(16'hFFFF, 16'h0000, 16'h0000, 16'h0000),
               make_row(16'h0800, 16'h0800, 16'h0800, 16'hFFFF), 1'b0);
    send_vertex(16'sd1, 16'sd0, 16'sd0, 1'b1);
    send_vertex(-16'sd1, 16'sd1, -16'sd1, 1'b1);
    send_vertex(16'sd4095, -16'sd4096, 16'sd3, 1'b0);
    send_vertex(-16'sd4097, 16'sd4097, -16'sd3, 1'b1);

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      no_idle = (phase % 4 == 3);
      write_rows(pick_row(), pick_row(), pick_row(), $urandom_range(0, 3) == 0);
      remaining = PHASE_VERTICES;
      while (remaining != 0) begin
        set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        if (set_len > remaining) set_len = remaining;
        send_set(set_len);
        remaining -= set_len;
      end
    end
    drain();

    if (mismatches == 0 && boxes_due == 0) begin
      $display("transformed_vertex_bounding_box_unit verification clean");
    end else begin
      $display("transformed_vertex_bounding_box_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tvb_pkg.sv
sv/transformed_vertex_bounding_box_unit.sv
sv/tvb_checker.sv
bench/tvb_box_checker.sv
bench/tb_transformed_vertex_bounding_box_unit.sv
